@@ src/rdsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_pkg
// Shared types, constants and CRC helper for the RDS group generator.
// ----------------------------------------------------------------------------
package rdsg_pkg;

    // Radiotext store geometry: four byte banks, one row per RT segment
    localparam int RT_LENGTH = 64;
    localparam int RT_BANKS  = 4;
    localparam int RT_ROWS   = RT_LENGTH / RT_BANKS;
    localparam int RT_IDX_W  = $clog2(RT_LENGTH);
    localparam int RT_BANK_W = $clog2(RT_BANKS);
    localparam int RT_ROW_W  = $clog2(RT_ROWS);

    // Field and block widths
    localparam int CHAR_W     = 8;
    localparam int INFO_W     = 16;
    localparam int CRC_W      = 10;
    localparam int PS_TEXT_W  = 64;
    localparam int PS_CHARS   = PS_TEXT_W / CHAR_W;
    localparam int BLOCKS     = 4;
    localparam int GROUP_BITS = BLOCKS * (INFO_W + CRC_W);
    localparam int GROUP_BYTES = GROUP_BITS / CHAR_W;
    localparam int BYTE_CNT_W = $clog2(GROUP_BYTES);
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE_CNT = BYTE_CNT_W'(GROUP_BYTES - 1);

    // Group pattern: PS groups first, then RT groups
    localparam int POS_W       = 5;
    localparam int PS_SEG_W    = 2;
    localparam int PATTERN_LEN = 20;
    localparam int PS_GROUPS   = 4;
    localparam logic [POS_W-1:0] PATTERN_LAST = POS_W'(PATTERN_LEN - 1);
    localparam logic [POS_W-1:0] PS_GROUP_END = POS_W'(PS_GROUPS);

    // Block constants
    localparam logic [INFO_W-1:0] BLK_B_0A = 16'h0400;
    localparam logic [INFO_W-1:0] TA_FLAG  = 16'h0010;
    localparam logic [INFO_W-1:0] BLK_C_0A = 16'hCDCD;
    localparam logic [INFO_W-1:0] BLK_B_2A = 16'h2400;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CRC_W-1:0]  CRC_POLY = 10'h1B9;

    // Configuration reset values
    localparam logic [PS_TEXT_W-1:0] PS_TEXT_RST = 64'h2020_2020_2020_2020;
    localparam logic [CRC_W-1:0] OFS_A_RST = 10'd252;
    localparam logic [CRC_W-1:0] OFS_B_RST = 10'd408;
    localparam logic [CRC_W-1:0] OFS_C_RST = 10'd360;
    localparam logic [CRC_W-1:0] OFS_D_RST = 10'd436;

    // FIFO between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic
    {
        OP_GENERATE = 1'b0,
        OP_WRITE_RT = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_PI_CODE  = 3'd0,
        CFG_TA       = 3'd1,
        CFG_PS_TEXT  = 3'd2,
        CFG_OFS_A    = 3'd3,
        CFG_OFS_B    = 3'd4,
        CFG_OFS_C    = 3'd5,
        CFG_OFS_D    = 3'd6
    } cfg_index_t;

    typedef struct packed
    {
        logic [INFO_W-1:0]    pi_code;
        logic                 traffic_announce;
        logic [PS_TEXT_W-1:0] ps_text;
        logic [CRC_W-1:0]     ofs_a;
        logic [CRC_W-1:0]     ofs_b;
        logic [CRC_W-1:0]     ofs_c;
        logic [CRC_W-1:0]     ofs_d;
    } cfg_t;

    // One group on its way to the serializer: blocks plus high-byte CRC
    typedef struct packed
    {
        logic [INFO_W-1:0] blk_a;
        logic [INFO_W-1:0] blk_b;
        logic [INFO_W-1:0] blk_c;
        logic [INFO_W-1:0] blk_d;
        logic [CRC_W-1:0]  part_a;
        logic [CRC_W-1:0]  part_b;
        logic [CRC_W-1:0]  part_c;
        logic [CRC_W-1:0]  part_d;
    } grp_t;

    // Advance the block CRC over one byte, MSB first
    function automatic logic [CRC_W-1:0] crc_step8(input logic [CRC_W-1:0] crc_in,
                                                   input logic [CHAR_W-1:0] data);
        logic [CRC_W-1:0] r;
        logic             fb;
        r = crc_in;
        for (int k = CHAR_W - 1; k >= 0; k--)
        begin
            fb = data[k] ^ r[CRC_W-1];
            r  = {r[CRC_W-2:0], 1'b0};
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Send a zero character as a space
    function automatic logic [CHAR_W-1:0] space_fix(input logic [CHAR_W-1:0] c);
        return (c == '0) ? SPACE_CHAR : c;
    endfunction

endpackage

@@ src/rdsg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_if
// Valid/ready channels of the RDS group generator: request, response, config.
// ----------------------------------------------------------------------------
interface rdsg_in_if import rdsg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [RT_IDX_W-1:0] text_index;
    logic [CHAR_W-1:0]   text_char;

    modport source (output valid, output opcode, output text_index, output text_char,
                    input ready);
    modport sink   (input valid, input opcode, input text_index, input text_char,
                    output ready);
endinterface

interface rdsg_out_if import rdsg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_byte;
    logic              last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

interface rdsg_cfg_if import rdsg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/rdsg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/rdsg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_front
// Accepts requests, stores radiotext, walks the group pattern and builds the
// information blocks of each group with their high-byte CRC.
// ----------------------------------------------------------------------------
module rdsg_front import rdsg_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    rdsg_in_if.sink       req,
    output logic          push_valid,
    input  logic          push_ready,
    output grp_t          push_data
);

    // Group pattern state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [PS_SEG_W-1:0] ps_seg_reg, ps_seg_next;
    logic [RT_ROW_W-1:0] rt_seg_reg, rt_seg_next;
    logic [RT_LENGTH-1:0] rt_valid_reg;

    // Build stage
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_is_ps_reg;
    logic [RT_ROW_W-1:0] s1_seg_reg;
    logic [RT_BANKS-1:0] s1_ok_reg;

    logic                accept, gen_acc, wr_acc, is_ps;
    logic [RT_BANK_W-1:0] wr_bank;
    logic [RT_ROW_W-1:0]  wr_row;
    logic [CHAR_W-1:0]    wr_char;
    logic [RT_BANKS-1:0]  bank_we;
    logic [RT_BANKS-1:0]  rd_ok;
    logic [CHAR_W-1:0]    rd_char [RT_BANKS];
    logic [CHAR_W-1:0]    rt_ch   [RT_BANKS];
    logic [CHAR_W-1:0]    ps_ch   [PS_CHARS];
    logic [PS_SEG_W-1:0]  s1_ps_seg;
    logic [INFO_W-1:0]    blk_b, blk_c, blk_d;

    assign req.ready = !s1_valid_reg || push_ready;
    assign accept    = req.valid && req.ready;
    assign gen_acc   = accept && (req.opcode == OP_GENERATE);
    assign wr_acc    = accept && (req.opcode == OP_WRITE_RT);
    assign is_ps     = pos_reg < PS_GROUP_END;

    assign wr_bank = req.text_index[RT_BANK_W-1:0];
    assign wr_row  = req.text_index[RT_IDX_W-1:RT_BANK_W];
    assign wr_char = space_fix(req.text_char);

    // Radiotext banks: character 4*s+k sits in bank k, row s
    for (genvar b = 0; b < RT_BANKS; b++)
    begin : g_bank
        assign bank_we[b] = wr_acc && (wr_bank == RT_BANK_W'(b));
        assign rd_ok[b]   = rt_valid_reg[{rt_seg_reg, RT_BANK_W'(b)}];

        rdsg_ram #(
            .WIDTH (CHAR_W),
            .DEPTH (RT_ROWS)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (wr_row),
            .wdata (wr_char),
            .re    (gen_acc),
            .raddr (rt_seg_reg),
            .rdata (rd_char[b])
        );
    end

    // Advance the pattern on each generate beat
    always_comb
    begin
        pos_next    = pos_reg;
        ps_seg_next = ps_seg_reg;
        rt_seg_next = rt_seg_reg;
        if (gen_acc)
        begin
            pos_next = (pos_reg == PATTERN_LAST) ? '0 : pos_reg + 1'b1;
            if (is_ps)
            begin
                ps_seg_next = ps_seg_reg + 1'b1;
            end
            else
            begin
                rt_seg_next = rt_seg_reg + 1'b1;
            end
        end
    end

    // Fill the build stage on generate, drain it into the queue
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (gen_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            ps_seg_reg   <= '0;
            rt_seg_reg   <= '0;
            rt_valid_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            ps_seg_reg   <= ps_seg_next;
            rt_seg_reg   <= rt_seg_next;
            s1_valid_reg <= s1_valid_next;
            if (wr_acc)
            begin
                rt_valid_reg[req.text_index] <= 1'b1;
            end
        end
    end

    // Capture group kind and segment with the bank reads
    always_ff @(posedge clk)
    begin
        if (gen_acc)
        begin
            s1_is_ps_reg <= is_ps;
            s1_seg_reg   <= is_ps ? RT_ROW_W'(ps_seg_reg) : rt_seg_reg;
            s1_ok_reg    <= rd_ok;
        end
    end

    // Select characters; unwritten radiotext reads as space
    always_comb
    begin
        for (int k = 0; k < RT_BANKS; k++)
        begin
            rt_ch[k] = s1_ok_reg[k] ? rd_char[k] : SPACE_CHAR;
        end
        for (int i = 0; i < PS_CHARS; i++)
        begin
            ps_ch[i] = cfg.ps_text[PS_TEXT_W - 1 - CHAR_W * i -: CHAR_W];
        end
    end

    assign s1_ps_seg = s1_seg_reg[PS_SEG_W-1:0];

    // Assemble blocks B, C and D
    always_comb
    begin
        if (s1_is_ps_reg)
        begin
            blk_b = BLK_B_0A | (cfg.traffic_announce ? TA_FLAG : '0) | INFO_W'(s1_ps_seg);
            blk_c = BLK_C_0A;
            blk_d = {space_fix(ps_ch[{s1_ps_seg, 1'b0}]),
                     space_fix(ps_ch[{s1_ps_seg, 1'b1}])};
        end
        else
        begin
            blk_b = BLK_B_2A | INFO_W'(s1_seg_reg);
            blk_c = {rt_ch[0], rt_ch[1]};
            blk_d = {rt_ch[2], rt_ch[3]};
        end
    end

    assign push_valid       = s1_valid_reg;
    assign push_data.blk_a  = cfg.pi_code;
    assign push_data.blk_b  = blk_b;
    assign push_data.blk_c  = blk_c;
    assign push_data.blk_d  = blk_d;
    assign push_data.part_a = crc_step8('0, cfg.pi_code[INFO_W-1:CHAR_W]);
    assign push_data.part_b = crc_step8('0, blk_b[INFO_W-1:CHAR_W]);
    assign push_data.part_c = crc_step8('0, blk_c[INFO_W-1:CHAR_W]);
    assign push_data.part_d = crc_step8('0, blk_d[INFO_W-1:CHAR_W]);

endmodule

@@ src/rdsg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_fifo
// Short group queue between the front and the serializer.
// ----------------------------------------------------------------------------
module rdsg_fifo import rdsg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  grp_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output grp_t pop_data
);

    grp_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store the pushed group
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/rdsg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_back
// Finishes the checkwords, frames the 104-bit group and sends it one byte
// per beat through an output register.
// ----------------------------------------------------------------------------
module rdsg_back import rdsg_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  grp_t      pop_data,
    rdsg_out_if.source rsp
);

    logic [GROUP_BITS-1:0] sh_reg;
    logic                  sh_valid_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic                  out_valid_reg;
    logic [CHAR_W-1:0]     out_byte_reg;
    logic                  out_last_reg;

    logic                  out_free, emit, last_emit, do_pop;
    logic [GROUP_BITS-1:0] frame;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign emit      = sh_valid_reg && out_free;
    assign last_emit = emit && (cnt_reg == LAST_BYTE_CNT);
    assign pop_ready = !sh_valid_reg || last_emit;
    assign do_pop    = pop_valid && pop_ready;

    // Complete each checkword over the low byte and apply its offset word
    assign frame = {pop_data.blk_a,
                    crc_step8(pop_data.part_a, pop_data.blk_a[CHAR_W-1:0]) ^ cfg.ofs_a,
                    pop_data.blk_b,
                    crc_step8(pop_data.part_b, pop_data.blk_b[CHAR_W-1:0]) ^ cfg.ofs_b,
                    pop_data.blk_c,
                    crc_step8(pop_data.part_c, pop_data.blk_c[CHAR_W-1:0]) ^ cfg.ofs_c,
                    pop_data.blk_d,
                    crc_step8(pop_data.part_d, pop_data.blk_d[CHAR_W-1:0]) ^ cfg.ofs_d};

    // Serializer and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sh_valid_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_pop)
            begin
                sh_valid_reg <= 1'b1;
                cnt_reg      <= '0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_emit)
                begin
                    sh_valid_reg <= 1'b0;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load a new frame or shift out the top byte
    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            sh_reg <= frame;
        end
        else if (emit)
        begin
            sh_reg <= {sh_reg[GROUP_BITS-CHAR_W-1:0], {CHAR_W{1'b0}}};
        end

        if (emit)
        begin
            out_byte_reg <= sh_reg[GROUP_BITS-1 -: CHAR_W];
            out_last_reg <= cnt_reg == LAST_BYTE_CNT;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.out_byte  = out_byte_reg;
    assign rsp.last_byte = out_last_reg;

endmodule

@@ src/rds_group_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rds_group_generator
// RDS group generator: 0A/2A group pattern with offset-word checkwords.
// ----------------------------------------------------------------------------
// A generate request (opcode 0) yields one 26-bit-per-block RDS group as 13
// output beats, MSB first, with last_byte set on the thirteenth; the first
// byte passes the build stage, group queue, shift and output registers. A
// radiotext write (opcode 1) yields no output. Requests are taken every cycle
// while the two-entry group queue has room; the sustained rate is set by the
// byte serializer, which sends one byte per cycle while the output is ready.
// The 64-character radiotext store sits in four byte-wide RAM banks and reads
// as spaces until written, with no clearing pass after reset. Configuration
// registers are written via the always-ready config channel; the user must
// write them only while no group is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rds_group_generator import rdsg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    rdsg_cfg_if.sink    cfg,
    rdsg_in_if.sink     req,
    rdsg_out_if.source  rsp
);

    cfg_t cfg_reg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    grp_t push_data, pop_data;

    assign cfg.ready = 1'b1;

    // Configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pi_code          <= '0;
            cfg_reg.traffic_announce <= 1'b0;
            cfg_reg.ps_text          <= PS_TEXT_RST;
            cfg_reg.ofs_a            <= OFS_A_RST;
            cfg_reg.ofs_b            <= OFS_B_RST;
            cfg_reg.ofs_c            <= OFS_C_RST;
            cfg_reg.ofs_d            <= OFS_D_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PI_CODE: cfg_reg.pi_code          <= cfg.data[INFO_W-1:0];
                CFG_TA:      cfg_reg.traffic_announce <= cfg.data[0];
                CFG_PS_TEXT: cfg_reg.ps_text          <= cfg.data[PS_TEXT_W-1:0];
                CFG_OFS_A:   cfg_reg.ofs_a            <= cfg.data[CRC_W-1:0];
                CFG_OFS_B:   cfg_reg.ofs_b            <= cfg.data[CRC_W-1:0];
                CFG_OFS_C:   cfg_reg.ofs_c            <= cfg.data[CRC_W-1:0];
                CFG_OFS_D:   cfg_reg.ofs_d            <= cfg.data[CRC_W-1:0];
                default:     ;
            endcase
        end
    end

    rdsg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rdsg_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rdsg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp       (rsp)
    );

endmodule

@@ src/rdsg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_assertions
// Port-level checks of the RDS group generator: group framing and ordering.
// ----------------------------------------------------------------------------
module rdsg_assertions import rdsg_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              req_opcode,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [CHAR_W-1:0] rsp_out_byte,
    input logic              rsp_last_byte
);

    logic [BYTE_CNT_W-1:0] byte_cnt_reg;
    logic [3:0]            pending_reg;
    logic                  gen_beat, rsp_beat, grp_done;

    assign gen_beat = req_valid && req_ready && (req_opcode == OP_GENERATE);
    assign rsp_beat = rsp_valid && rsp_ready;
    assign grp_done = rsp_beat && rsp_last_byte;

    // Count output beats within a group and groups still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (rsp_beat)
            begin
                byte_cnt_reg <= (byte_cnt_reg == LAST_BYTE_CNT) ? '0 : byte_cnt_reg + 1'b1;
            end
            pending_reg <= pending_reg + {3'b0, gen_beat} - {3'b0, grp_done};
        end
    end

    // Hold a stalled output beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                    && $stable(rsp_last_byte))
        else $error("output beat changed while stalled");

    // Mark exactly the thirteenth beat of each group
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_beat |-> (rsp_last_byte == (byte_cnt_reg == LAST_BYTE_CNT)))
        else $error("last_byte out of place");

    // Emit only for a generate request already taken
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != '0)
        else $error("output beat without a pending generate request");

endmodule

bind rds_group_generator rdsg_assertions u_rdsg_assertions (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_opcode    (req.opcode),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_out_byte  (rsp.out_byte),
    .rsp_last_byte (rsp.last_byte)
);

@@ test/rdsg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsg_checker
// Watches the config, request and response channels of the RDS group
// generator. Keeps its own copy of the registers, the group pattern and the
// radiotext store, and works out the thirteen bytes of every requested group.
// Each response beat is compared field by field with the oldest owed byte.
// ----------------------------------------------------------------------------
module rdsg_checker import rdsg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    rdsg_cfg_if  cfg,
    rdsg_in_if   req,
    rdsg_out_if  rsp,
    output int   fail_count,
    output int   beats_pending
);

    localparam logic [9:0]  CHECK_POLY = 10'h1B9;
    localparam logic [15:0] GRP_0A_B   = 16'h0400;
    localparam logic [15:0] TA_BIT     = 16'h0010;
    localparam logic [15:0] FILL_0A_C  = 16'hCDCD;
    localparam logic [15:0] GRP_2A_B   = 16'h2400;
    localparam logic [7:0]  BLANK      = 8'h20;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last;
    } group_beat_t;

    cfg_t        settings;
    logic [7:0]  rt_store [RT_LENGTH];
    logic [4:0]  pattern_pos;
    logic [1:0]  ps_seg;
    logic [3:0]  rt_seg;
    group_beat_t owed_bytes [$];
    int          mismatches = 0;

    assign fail_count = mismatches;

    // Checkword of one 16-bit information block, MSB first
    function automatic logic [9:0] block_checkword(input logic [15:0] info);
        logic [9:0] r;
        logic       fb;
        r = '0;
        for (int k = 15; k >= 0; k--)
        begin
            fb = info[k] ^ r[9];
            r  = {r[8:0], 1'b0};
            if (fb)
            begin
                r = r ^ CHECK_POLY;
            end
        end
        return r;
    endfunction

    // PS character n, character 0 in the top byte; zero goes out as a space
    function automatic logic [7:0] ps_glyph(input cfg_t s, input int n);
        logic [7:0] c;
        c = s.ps_text[63 - 8 * n -: 8];
        return (c == 8'h00) ? BLANK : c;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns rdsg_checker: %s", $time, what);
    endtask

    // Build the next group of the pattern and queue its thirteen bytes
    task automatic predict_group();
        logic [15:0]  blk [4];
        logic [103:0] bits;
        group_beat_t  beat;
        blk[0] = settings.pi_code;
        if (pattern_pos < PS_GROUPS)
        begin
            blk[1] = GRP_0A_B | {14'b0, ps_seg} |
                     (settings.traffic_announce ? TA_BIT : 16'h0000);
            blk[2] = FILL_0A_C;
            blk[3] = {ps_glyph(settings, 2 * int'(ps_seg)),
                      ps_glyph(settings, 2 * int'(ps_seg) + 1)};
            ps_seg = ps_seg + 2'd1;
        end
        else
        begin
            blk[1] = GRP_2A_B | {12'b0, rt_seg};
            blk[2] = {rt_store[4 * int'(rt_seg)],     rt_store[4 * int'(rt_seg) + 1]};
            blk[3] = {rt_store[4 * int'(rt_seg) + 2], rt_store[4 * int'(rt_seg) + 3]};
            rt_seg = rt_seg + 4'd1;
        end
        pattern_pos = (pattern_pos == 5'(PATTERN_LEN - 1)) ? 5'd0 : pattern_pos + 5'd1;

        bits = {blk[0], block_checkword(blk[0]) ^ settings.ofs_a,
                blk[1], block_checkword(blk[1]) ^ settings.ofs_b,
                blk[2], block_checkword(blk[2]) ^ settings.ofs_c,
                blk[3], block_checkword(blk[3]) ^ settings.ofs_d};
        for (int i = 0; i < GROUP_BYTES; i++)
        begin
            beat.data = bits[103 - 8 * i -: 8];
            beat.last = (i == GROUP_BYTES - 1);
            owed_bytes.push_back(beat);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        group_beat_t want;
        if (!rst_n)
        begin
            settings.pi_code          = '0;
            settings.traffic_announce = 1'b0;
            settings.ps_text          = PS_TEXT_RST;
            settings.ofs_a            = OFS_A_RST;
            settings.ofs_b            = OFS_B_RST;
            settings.ofs_c            = OFS_C_RST;
            settings.ofs_d            = OFS_D_RST;
            pattern_pos = '0;
            ps_seg      = '0;
            rt_seg      = '0;
            foreach (rt_store[k])
            begin
                rt_store[k] = BLANK;
            end
            owed_bytes.delete();
            beats_pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_PI_CODE: settings.pi_code          = cfg.data[15:0];
                    CFG_TA:      settings.traffic_announce = cfg.data[0];
                    CFG_PS_TEXT: settings.ps_text          = cfg.data;
                    CFG_OFS_A:   settings.ofs_a            = cfg.data[9:0];
                    CFG_OFS_B:   settings.ofs_b            = cfg.data[9:0];
                    CFG_OFS_C:   settings.ofs_c            = cfg.data[9:0];
                    CFG_OFS_D:   settings.ofs_d            = cfg.data[9:0];
                    default: ;
                endcase
            end

            // Compare each response beat with the oldest owed byte
            if (rsp.valid && rsp.ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %02h last %0b",
                                              rsp.out_byte, rsp.last_byte));
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (rsp.out_byte !== want.data)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  rsp.out_byte, want.data));
                    end
                    if (rsp.last_byte !== want.last)
                    begin
                        report_mismatch($sformatf("last_byte %0b, expected %0b",
                                                  rsp.last_byte, want.last));
                    end
                end
            end

            // Apply each request beat: store a character or predict a group
            if (req.valid && req.ready)
            begin
                if (opcode_t'(req.opcode) == OP_WRITE_RT)
                begin
                    rt_store[req.text_index] = (req.text_char == 8'h00) ? BLANK
                                                                         : req.text_char;
                end
                else
                begin
                    predict_group();
                end
            end
            beats_pending <= owed_bytes.size();
        end
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the RDS group generator. Drives a short directed run over
// the register extremes and zero characters, then random request streams
// under four idle/stall phases with fresh register settings in between. A
// checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module tb;
    import rdsg_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int PHASE_ITEMS    = 115;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   beats_pending;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   quiet_cycles = 0;

    rdsg_in_if  req_ch ();
    rdsg_out_if rsp_ch ();
    rdsg_cfg_if cfg_ch ();

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rds_group_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rdsg_checker i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    // Stall the response side at random
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // End the run if no beat moves on any channel for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** rds_group_generator: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request beat after a random idle gap; hold valid afterward
    task automatic send_item(input opcode_t op, input logic [5:0] idx,
                             input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op;
        req_ch.text_index <= idx;
        req_ch.text_char  <= ch;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic cfg_beat(input cfg_index_t idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Write every register, then drop valid
    task automatic load_settings(input cfg_t s);
        cfg_beat(CFG_PI_CODE, 64'(s.pi_code));
        cfg_beat(CFG_TA,      64'(s.traffic_announce));
        cfg_beat(CFG_PS_TEXT, s.ps_text);
        cfg_beat(CFG_OFS_A,   64'(s.ofs_a));
        cfg_beat(CFG_OFS_B,   64'(s.ofs_b));
        cfg_beat(CFG_OFS_C,   64'(s.ofs_c));
        cfg_beat(CFG_OFS_D,   64'(s.ofs_d));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop requests and wait until every owed byte has come out
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (beats_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cfg_t random_settings();
        cfg_t s;
        s.pi_code          = 16'($urandom);
        s.traffic_announce = 1'($urandom_range(1));
        s.ps_text          = {$urandom, $urandom};
        // Blank out some PS characters so zero bytes turn up
        for (int k = 0; k < 8; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                s.ps_text[8 * k +: 8] = 8'h00;
            end
        end
        s.ofs_a = 10'($urandom_range(1023));
        s.ofs_b = 10'($urandom_range(1023));
        s.ofs_c = 10'($urandom_range(1023));
        s.ofs_d = 10'($urandom_range(1023));
        return s;
    endfunction

    task automatic random_phase(input int idle, input int stall);
        logic [7:0] ch;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            if ($urandom_range(99) < 60)
            begin
                send_item(OP_GENERATE, 6'($urandom), 8'($urandom));
            end
            else
            begin
                ch = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom);
                send_item(OP_WRITE_RT, 6'($urandom_range(63)), ch);
            end
        end
        drain();
    endtask

    initial
    begin
        cfg_t top_cfg;
        cfg_t zero_cfg;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= OP_GENERATE;
        req_ch.text_index <= '0;
        req_ch.text_char  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_PI_CODE;
        cfg_ch.data       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: radiotext edges, zero character, first PS segments
        send_item(OP_WRITE_RT, 6'd0,  8'h00);
        send_item(OP_WRITE_RT, 6'd3,  8'hFF);
        send_item(OP_WRITE_RT, 6'd5,  8'h80);
        send_item(OP_WRITE_RT, 6'd6,  8'h01);
        send_item(OP_WRITE_RT, 6'd63, 8'hFF);
        send_item(OP_GENERATE, 6'd0,  8'h00);
        send_item(OP_GENERATE, 6'd63, 8'hFF);
        drain();

        // All-ones PI code, TA flag and offsets; zero PS characters in the remaining segments
        top_cfg.pi_code          = 16'hFFFF;
        top_cfg.traffic_announce = 1'b1;
        top_cfg.ps_text          = 64'hFF41_7E01_00FF_2000;
        top_cfg.ofs_a            = 10'h3FF;
        top_cfg.ofs_b            = 10'h3FF;
        top_cfg.ofs_c            = 10'h3FF;
        top_cfg.ofs_d            = 10'h3FF;
        load_settings(top_cfg);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        drain();

        // All-zero registers; radiotext segments with the written characters
        zero_cfg = '0;
        load_settings(zero_cfg);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        send_item(OP_WRITE_RT, 6'd16, 8'h5A);
        send_item(OP_GENERATE, 6'd0, 8'h00);
        drain();

        // Random streams under each idle/stall mix
        load_settings(random_settings());
        random_phase(0, 0);
        load_settings(random_settings());
        random_phase(63, 0);
        load_settings(random_settings());
        random_phase(0, 63);
        load_settings(random_settings());
        random_phase(20, 20);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("** rds_group_generator: PASSED **");
        end
        else
        begin
            $display("** rds_group_generator: FAILED **");
        end
        $finish;
    end

endmodule
